/* sv/lqfl_pkg.sv */
// Shared types and constants for the linked queue with free list.
// No dependencies; used by lqfl_ctrl, lqfl_datapath and the top level.
`default_nettype none

package lqfl_pkg;

    // operation code carried on s_tuser
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result flag positions on m_tuser
    localparam int OUT_USER_W   = 3;
    localparam int USER_ACCEPT  = 0;
    localparam int USER_EMPTY   = 1;
    localparam int USER_FULL    = 2;

    localparam int IO_DATA_W = 32;

    // controller to datapath commands
    typedef struct packed {
        logic start;   // latch transaction, launch memory reads
        logic exec;    // apply list update, load result register
    } lqfl_cmd_t;

endpackage

`default_nettype wire

/* sv/lqfl_ctrl.sv */
// Sequencer for the linked queue: accept, execute, result handshake.
// Depends on lqfl_pkg for the command struct.
`default_nettype none

module lqfl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output lqfl_pkg::lqfl_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_load;

    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        can_load  = !out_valid_reg || m_tready;
        cmd.start = s_tvalid && (state_reg == ST_IDLE);
        cmd.exec  = (state_reg == ST_EXEC) && can_load;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.exec) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.exec) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

/* sv/lqfl_datapath.sv */
// Node store, list pointers and result register of the linked queue.
// Depends on lqfl_pkg; driven by lqfl_ctrl commands.
`default_nettype none

module lqfl_datapath #(
    parameter int NODE_COUNT = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire lqfl_pkg::lqfl_cmd_t                 cmd,
    input  wire logic                                in_kind,
    input  wire logic [lqfl_pkg::IO_DATA_W-1:0]      in_data,
    output logic [lqfl_pkg::IO_DATA_W-1:0]           out_data,
    output logic [lqfl_pkg::OUT_USER_W-1:0]          out_user
);

    localparam int IDX_W   = $clog2(NODE_COUNT + 1);
    localparam int ADDR_W  = $clog2(NODE_COUNT);
    localparam int STORE_W = (DATA_WIDTH < lqfl_pkg::IO_DATA_W) ? DATA_WIDTH
                                                                : lqfl_pkg::IO_DATA_W;
    localparam logic [IDX_W-1:0] NIL = IDX_W'(NODE_COUNT);

    logic [STORE_W-1:0] payload_mem [NODE_COUNT];
    logic [IDX_W-1:0]   link_mem    [NODE_COUNT];

    logic [IDX_W-1:0]   free_head_reg, free_head_next;
    logic [IDX_W-1:0]   queue_head_reg, queue_head_next;
    logic [IDX_W-1:0]   queue_tail_reg, queue_tail_next;
    // nodes below this count were never taken; their link is implied
    logic [IDX_W-1:0]   fresh_reg, fresh_next;

    logic               kind_reg;
    logic [STORE_W-1:0] data_reg;
    logic [IDX_W-1:0]   node_reg;
    logic [STORE_W-1:0] payload_q_reg;
    logic [IDX_W-1:0]   link_q_reg;

    logic [lqfl_pkg::IO_DATA_W-1:0]  out_data_reg, out_data_next;
    logic [lqfl_pkg::OUT_USER_W-1:0] out_user_reg, out_user_next;

    logic [IDX_W-1:0]  sel_node;
    logic [IDX_W-1:0]  link_val;
    logic              node_ok;
    logic              link_we;
    logic [ADDR_W-1:0] link_waddr;
    logic [IDX_W-1:0]  link_wdata;
    logic              pay_we;

    assign sel_node = (in_kind == lqfl_pkg::KIND_DEQ) ? queue_head_reg : free_head_reg;

    always_comb begin
        if (node_reg < fresh_reg) begin
            link_val = (node_reg == '0) ? NIL : node_reg - IDX_W'(1);
        end else begin
            link_val = link_q_reg;
        end

        node_ok         = (node_reg < NIL);
        free_head_next  = free_head_reg;
        queue_head_next = queue_head_reg;
        queue_tail_next = queue_tail_reg;
        fresh_next      = fresh_reg;
        link_we         = 1'b0;
        link_waddr      = node_reg[ADDR_W-1:0];
        link_wdata      = free_head_reg;
        pay_we          = 1'b0;
        out_data_next   = '0;

        if (kind_reg == lqfl_pkg::KIND_ENQ) begin
            if (node_ok) begin
                pay_we         = 1'b1;
                free_head_next = (link_val < NIL) ? link_val : NIL;
                if (node_reg < fresh_reg) begin
                    fresh_next = node_reg;
                end
                // the new tail's link is never read, so only the old tail is relinked
                if (queue_tail_reg < NIL) begin
                    link_we    = 1'b1;
                    link_waddr = queue_tail_reg[ADDR_W-1:0];
                    link_wdata = node_reg;
                end else begin
                    queue_head_next = node_reg;
                end
                queue_tail_next = node_reg;
            end
        end else begin
            if (node_ok) begin
                out_data_next  = lqfl_pkg::IO_DATA_W'(payload_q_reg);
                link_we        = 1'b1;
                free_head_next = node_reg;
                if (node_reg == queue_tail_reg || !(link_val < NIL)) begin
                    queue_head_next = NIL;
                    queue_tail_next = NIL;
                end else begin
                    queue_head_next = link_val;
                end
            end
        end

        out_user_next                         = '0;
        out_user_next[lqfl_pkg::USER_ACCEPT]  = node_ok;
        out_user_next[lqfl_pkg::USER_EMPTY]   = !(queue_head_next < NIL);
        out_user_next[lqfl_pkg::USER_FULL]    = !(free_head_next < NIL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg  <= NIL - IDX_W'(1);
            queue_head_reg <= NIL;
            queue_tail_reg <= NIL;
            fresh_reg      <= NIL;
        end else if (cmd.exec) begin
            free_head_reg  <= free_head_next;
            queue_head_reg <= queue_head_next;
            queue_tail_reg <= queue_tail_next;
            fresh_reg      <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            kind_reg <= in_kind;
            data_reg <= in_data[STORE_W-1:0];
            node_reg <= sel_node;
        end
        if (cmd.exec) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    // node store: one write and one registered read per memory
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            payload_q_reg <= payload_mem[sel_node[ADDR_W-1:0]];
            link_q_reg    <= link_mem[sel_node[ADDR_W-1:0]];
        end
        if (cmd.exec && pay_we) begin
            payload_mem[node_reg[ADDR_W-1:0]] <= data_reg;
        end
        if (cmd.exec && link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

endmodule

`default_nettype wire

/* sv/linked_queue_with_free_list_core.sv */
// Linked-list FIFO queue in a fixed node store with a free list of unused nodes.
// Transactions in on s_*: s_tuser = kind (0 enqueue s_tdata, 1 dequeue head).
// Each transaction gives exactly one result transaction on m_*:
//   m_tdata = removed payload on a successful dequeue, else 0;
//   m_tuser = {full_res, empty_res, accepted} from the highest bit down.
// An enqueue with no free node is dropped with accepted = 0; a dequeue on an
// empty queue returns accepted = 0 and zero data.
// Sequence: an accepted transaction launches the node store reads; the execute
// step then applies the list update and loads the result register, from which
// m_tvalid is driven. A new transaction is taken only after the last one has
// executed, set by the registered read of the link memory that the update needs.
// A waiting result does not block acceptance of the next transaction; only the
// execute step waits while the result register is still occupied, so m_tready
// low for long eventually holds s_tready low.
// Reset (aresetn low, synchronous) empties the queue and frees every node;
// no clearing pass is needed, so the block is ready on the first cycle after.
// Uses lqfl_pkg, lqfl_ctrl and lqfl_datapath.
`default_nettype none

module linked_queue_with_free_list_core #(
    parameter int NODE_COUNT = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [lqfl_pkg::IO_DATA_W-1:0]      s_tdata,   // [31:0] data
    input  wire logic                                s_tuser,   // [0] kind
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [lqfl_pkg::IO_DATA_W-1:0]           m_tdata,   // [31:0] out_data
    output logic [lqfl_pkg::OUT_USER_W-1:0]          m_tuser    // [0] accepted,
                                                                // [1] empty_res,
                                                                // [2] full_res
);

    lqfl_pkg::lqfl_cmd_t cmd;

    lqfl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lqfl_datapath #(
        .NODE_COUNT (NODE_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_kind  (s_tuser),
        .in_data  (s_tdata),
        .out_data (m_tdata),
        .out_user (m_tuser)
    );

endmodule

`default_nettype wire

/* verif/lqfl_checker.sv */
// Checker for linked_queue_with_free_list_core: watches both stream channels,
// predicts each result from its own copy of the node store and compares in order.
// Depends on lqfl_pkg for the kind codes and the m_tuser flag positions.
`default_nettype none

module lqfl_checker #(
    parameter int NODE_COUNT = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [lqfl_pkg::IO_DATA_W-1:0] s_tdata,   // [31:0] data
    input  wire logic                           s_tuser,   // [0] kind
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [lqfl_pkg::IO_DATA_W-1:0] m_tdata,   // [31:0] out_data
    input  wire logic [lqfl_pkg::OUT_USER_W-1:0] m_tuser,  // [0] accepted, [1] empty_res,
                                                           // [2] full_res
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(NODE_COUNT + 1);
    localparam logic [IDX_W-1:0] NIL = IDX_W'(NODE_COUNT);
    localparam logic [63:0] WORD_MASK =
        (DATA_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << DATA_WIDTH) - 64'd1);
    localparam int REPORT_MAX = 40;

    typedef struct {
        logic                           accepted;
        logic [lqfl_pkg::IO_DATA_W-1:0] out_data;
        logic                           empty_res;
        logic                           full_res;
    } queue_result_t;

    logic [63:0]      node_word [NODE_COUNT];
    logic [IDX_W-1:0] node_next [NODE_COUNT];
    logic [IDX_W-1:0] free_top;
    logic [IDX_W-1:0] q_head;
    logic [IDX_W-1:0] q_tail;

    queue_result_t expected_results[$];
    int reports;

    function automatic void clear_store();
        for (int i = 0; i < NODE_COUNT; i++) begin
            node_word[i] = '0;
            node_next[i] = (i == 0) ? NIL : IDX_W'(i - 1);
        end
        free_top = IDX_W'(NODE_COUNT - 1);
        q_head   = NIL;
        q_tail   = NIL;
    endfunction

    function automatic queue_result_t apply_queue_op(
        logic                           kind,
        logic [lqfl_pkg::IO_DATA_W-1:0] word
    );
        queue_result_t    r;
        logic [IDX_W-1:0] n;
        logic [63:0]      got;
        got = '0;
        r.accepted = 1'b0;
        if (kind == lqfl_pkg::KIND_ENQ) begin
            n = free_top;
            if (n != NIL) begin
                free_top     = node_next[n];
                node_word[n] = {32'd0, word} & WORD_MASK;
                node_next[n] = NIL;
                if (q_tail == NIL) q_head = n;
                else node_next[q_tail] = n;
                q_tail     = n;
                r.accepted = 1'b1;
            end
        end else begin
            n = q_head;
            if (n != NIL) begin
                got          = node_word[n];
                q_head       = node_next[n];
                node_next[n] = free_top;
                free_top     = n;
                if (q_head == NIL) q_tail = NIL;
                r.accepted = 1'b1;
            end
        end
        r.out_data  = got[lqfl_pkg::IO_DATA_W-1:0];
        r.empty_res = (q_head == NIL);
        r.full_res  = (free_top == NIL);
        return r;
    endfunction

    function automatic void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            if (reports < REPORT_MAX) begin
                reports++;
                $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, exp_v,
                         act_v);
            end
        end
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
        reports    = 0;
        clear_store();
    end

    always @(posedge aclk) begin
        queue_result_t e;
        if (!aresetn) begin
            clear_store();
            expected_results.delete();
        end else begin
            // result at this edge always belongs to an earlier input transaction
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (reports < REPORT_MAX) begin
                        reports++;
                        $display("%0t ns: unexpected result, expected none actual %h/%b",
                                 $time, m_tdata, m_tuser);
                    end
                end else begin
                    e = expected_results.pop_front();
                    report_field("accepted", 32'(e.accepted),
                                 32'(m_tuser[lqfl_pkg::USER_ACCEPT]));
                    report_field("out_data", e.out_data, m_tdata);
                    report_field("empty_res", 32'(e.empty_res),
                                 32'(m_tuser[lqfl_pkg::USER_EMPTY]));
                    report_field("full_res", 32'(e.full_res),
                                 32'(m_tuser[lqfl_pkg::USER_FULL]));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_queue_op(s_tuser, s_tdata));
        end
        pending <= expected_results.size();
    end

endmodule

`default_nettype wire

/* verif/tb_linked_queue_with_free_list_core.sv */
// Top of the linked queue testbench: clock, reset, bursty stimulus and a
// stalling receiver. Depends on lqfl_pkg, lqfl_checker and the core RTL.
`default_nettype none

module tb_linked_queue_with_free_list_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_OPS = 2000;
    localparam int HOLD_AFTER = 700;
    localparam int HOLD_CYCLES = 300;

    logic                                 aclk     = 1'b0;
    logic                                 aresetn  = 1'b0;
    logic                                 s_tvalid = 1'b0;
    wire logic                            s_tready;
    logic [lqfl_pkg::IO_DATA_W-1:0]       s_tdata  = '0;   // [31:0] data
    logic                                 s_tuser  = 1'b0; // [0] kind
    wire logic                            m_tvalid;
    logic                                 m_tready = 1'b0;
    wire logic [lqfl_pkg::IO_DATA_W-1:0]  m_tdata;    // [31:0] out_data
    wire logic [lqfl_pkg::OUT_USER_W-1:0] m_tuser;    // [0] accepted, [1] empty_res,
                                                      // [2] full_res

    int fail_count;
    int pending;
    int ops_sent  = 0;
    int burst_left = 0;
    bit hold_done = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    linked_queue_with_free_list_core #(.NODE_COUNT(16), .DATA_WIDTH(32)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    lqfl_checker #(.NODE_COUNT(16), .DATA_WIDTH(32)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    // offer one transaction and hold it until taken; gaps come between bursts
    task automatic send_op(input logic kind, input logic [lqfl_pkg::IO_DATA_W-1:0] word);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ops_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // receiver: segments of differing stall patterns, plus one long hold-off
    initial begin
        int seg_len;
        int mode;
        forever begin
            seg_len = $urandom_range(10, 120);
            mode    = $urandom_range(0, 3);
            for (int k = 0; k < seg_len; k++) begin
                @(posedge aclk);
                if (!hold_done && ops_sent >= HOLD_AFTER) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (k % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int enq_pct;
        enq_pct = 50;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty queue, extreme words, drain to empty, fill to full, overflow
        send_op(lqfl_pkg::KIND_DEQ, 32'hFFFF_FFFF);
        send_op(lqfl_pkg::KIND_ENQ, 32'hFFFF_FFFF);
        send_op(lqfl_pkg::KIND_ENQ, 32'h0000_0000);
        send_op(lqfl_pkg::KIND_DEQ, 32'h0000_0000);
        send_op(lqfl_pkg::KIND_DEQ, 32'h1234_5678);
        send_op(lqfl_pkg::KIND_DEQ, 32'h0000_0000);
        send_op(lqfl_pkg::KIND_ENQ, 32'hAAAA_AAAA);
        send_op(lqfl_pkg::KIND_ENQ, 32'h5555_5555);
        for (int i = 0; i < 14; i++) send_op(lqfl_pkg::KIND_ENQ, $urandom);
        send_op(lqfl_pkg::KIND_ENQ, 32'hDEAD_BEEF);

        // random: enqueue share shifts so the queue swings between full and empty
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 4))
                    0: enq_pct = 5;
                    1: enq_pct = 25;
                    2: enq_pct = 50;
                    3: enq_pct = 75;
                    default: enq_pct = 95;
                endcase
            end
            send_op(($urandom_range(0, 99) < enq_pct) ? lqfl_pkg::KIND_ENQ
                                                       : lqfl_pkg::KIND_DEQ, $urandom);
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
